// ===== rtl/sgfs_pkg.sv =====
// Shared constants, codes and types of the slot and global FIFO scheduler.
`timescale 1ns / 1ps
package sgfs_pkg;

   localparam int NUM_CPUS   = 8;
   localparam int MAX_TASKS  = 64;
   localparam int CPU_W      = 3;
   localparam int TASK_W     = 6;
   localparam int COUNT_W    = $clog2(MAX_TASKS + 1);
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

   typedef enum logic [1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_PICK    = 2'd2,
      OP_YIELD   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_DONE       = 3'd0,
      ST_ALREADY    = 3'd1,
      ST_NOT_QUEUED = 3'd2,
      ST_NOTHING    = 3'd3,
      ST_SLOT_EMPTY = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      CMD_ENQUEUE,
      CMD_DEQUEUE,
      CMD_PICK,
      CMD_YIELD,
      CMD_REJECT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      status_type        reject_status;
      logic [CPU_W-1:0]  cpu;
      logic [TASK_W-1:0] task_id;
   } cmd_type;

   typedef enum logic {
      BK_IDLE,
      BK_LINK
   } back_state_type;

endpackage

// ===== rtl/sgfs_front.sv =====
// Front end: accepts requests and classifies them into scheduler commands.
`timescale 1ns / 1ps
module sgfs_front (
   input  logic                        req_valid,
   input  logic [1:0]                  req_op,
   input  logic [2:0]                  req_cpu,
   input  logic [5:0]                  req_task_id,
   output logic                        req_stall,
   input  logic                        queue_full,
   output logic                        push,
   output sgfs_pkg::cmd_type           push_cmd
);
   import sgfs_pkg::*;

   logic cpu_ok;
   logic task_ok;

   assign cpu_ok    = int'(req_cpu) < NUM_CPUS;
   assign task_ok   = int'(req_task_id) < MAX_TASKS;
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // Checks that do not depend on scheduler state are settled here.
   always_comb begin
      push_cmd.cpu           = req_cpu;
      push_cmd.task_id       = req_task_id;
      push_cmd.kind          = CMD_REJECT;
      push_cmd.reject_status = ST_DONE;
      unique case (op_type'(req_op))
         OP_DEQUEUE: begin
            if (!task_ok) begin
               push_cmd.reject_status = ST_NOT_QUEUED;
            end else begin
               push_cmd.kind = CMD_DEQUEUE;
            end
         end
         OP_ENQUEUE: begin
            if (!cpu_ok) begin
               push_cmd.reject_status = ST_SLOT_EMPTY;
            end else if (!task_ok) begin
               push_cmd.reject_status = ST_NOT_QUEUED;
            end else begin
               push_cmd.kind = CMD_ENQUEUE;
            end
         end
         OP_PICK: begin
            if (!cpu_ok) begin
               push_cmd.reject_status = ST_SLOT_EMPTY;
            end else begin
               push_cmd.kind = CMD_PICK;
            end
         end
         OP_YIELD: begin
            if (!cpu_ok) begin
               push_cmd.reject_status = ST_SLOT_EMPTY;
            end else begin
               push_cmd.kind = CMD_YIELD;
            end
         end
      endcase
   end

endmodule

// ===== rtl/sgfs_cmdq.sv =====
// Short command queue between the front end and the execution back end.
`timescale 1ns / 1ps
module sgfs_cmdq (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sgfs_pkg::cmd_type   push_cmd,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output sgfs_pkg::cmd_type   head_cmd
);
   import sgfs_pkg::*;

   cmd_type               entry_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0] wr_ptr_ff;
   logic [CMDQ_PTR_W-1:0] wr_ptr_in;
   logic [CMDQ_PTR_W-1:0] rd_ptr_ff;
   logic [CMDQ_PTR_W-1:0] rd_ptr_in;
   logic [CMDQ_PTR_W:0]   count_ff;
   logic [CMDQ_PTR_W:0]   count_in;

   assign full       = count_ff == (CMDQ_PTR_W + 1)'(CMDQ_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/sgfs_back.sv =====
// Back end: slot table, global FIFO link memories and the result register.
`timescale 1ns / 1ps
module sgfs_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   input  sgfs_pkg::cmd_type   cmd,
   output logic                cmd_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_status,
   output logic                rsp_task_valid,
   output logic [5:0]          rsp_chosen_task
);
   import sgfs_pkg::*;

   back_state_type      state_ff, state_in;
   logic [NUM_CPUS-1:0] slot_valid_ff, slot_valid_in;
   logic [TASK_W-1:0]   slot_task_ff [NUM_CPUS];
   logic [TASK_W-1:0]   slot_task_in [NUM_CPUS];
   logic [MAX_TASKS-1:0] queued_ff, queued_in;
   logic [MAX_TASKS-1:0] in_global_ff, in_global_in;
   logic [TASK_W-1:0]   head_ff, head_in;
   logic [TASK_W-1:0]   tail_ff, tail_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [TASK_W-1:0]   rm_task_ff, rm_task_in;
   logic                pend_task_valid_ff, pend_task_valid_in;
   logic [TASK_W-1:0]   pend_chosen_ff, pend_chosen_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic                rsp_task_valid_ff, rsp_task_valid_in;
   logic [TASK_W-1:0]   rsp_chosen_ff, rsp_chosen_in;

   logic [TASK_W-1:0]   next_link_mem [MAX_TASKS];
   logic [TASK_W-1:0]   prev_link_mem [MAX_TASKS];
   logic [TASK_W-1:0]   next_rd_ff;
   logic [TASK_W-1:0]   prev_rd_ff;
   logic                rd_en;
   logic [TASK_W-1:0]   rd_addr;
   logic                next_we, prev_we;
   logic [TASK_W-1:0]   next_wa, next_wd, prev_wa, prev_wd;

   logic                out_free;
   logic                load;
   status_type          res_status;
   logic                res_task_valid;
   logic [TASK_W-1:0]   res_chosen;
   logic                app_en;
   logic [TASK_W-1:0]   app_task;
   logic                rm_en;
   logic [TASK_W-1:0]   rm_addr;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_task_valid  = rsp_task_valid_ff;
   assign rsp_chosen_task = rsp_chosen_ff;
   assign out_free        = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in           = state_ff;
      slot_valid_in      = slot_valid_ff;
      slot_task_in       = slot_task_ff;
      queued_in          = queued_ff;
      in_global_in       = in_global_ff;
      head_in            = head_ff;
      tail_in            = tail_ff;
      count_in           = count_ff;
      rm_task_in         = rm_task_ff;
      pend_task_valid_in = pend_task_valid_ff;
      pend_chosen_in     = pend_chosen_ff;
      cmd_pop            = 1'b0;
      rd_en              = 1'b0;
      rd_addr            = cmd.task_id;
      next_we            = 1'b0;
      next_wa            = '0;
      next_wd            = '0;
      prev_we            = 1'b0;
      prev_wa            = '0;
      prev_wd            = '0;
      load               = 1'b0;
      res_status         = ST_DONE;
      res_task_valid     = 1'b0;
      res_chosen         = '0;
      app_en             = 1'b0;
      app_task           = cmd.task_id;
      rm_en              = 1'b0;
      rm_addr            = cmd.task_id;

      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               load    = 1'b1;
               unique case (cmd.kind)
                  CMD_REJECT: begin
                     res_status = cmd.reject_status;
                  end
                  CMD_ENQUEUE: begin
                     if (queued_ff[cmd.task_id]) begin
                        res_status = ST_ALREADY;
                     end else begin
                        queued_in[cmd.task_id] = 1'b1;
                        if (!slot_valid_ff[cmd.cpu]) begin
                           slot_valid_in[cmd.cpu] = 1'b1;
                           slot_task_in[cmd.cpu]  = cmd.task_id;
                        end else begin
                           app_en = 1'b1;
                        end
                     end
                  end
                  CMD_DEQUEUE: begin
                     if (!queued_ff[cmd.task_id]) begin
                        res_status = ST_NOT_QUEUED;
                     end else begin
                        queued_in[cmd.task_id] = 1'b0;
                        if (in_global_ff[cmd.task_id]) begin
                           rm_en = 1'b1;
                        end else begin
                           // The task sits in some slot, not necessarily this CPU's.
                           for (int c = 0; c < NUM_CPUS; c++) begin
                              if (slot_valid_ff[c] && slot_task_ff[c] == cmd.task_id) begin
                                 slot_valid_in[c] = 1'b0;
                              end
                           end
                        end
                     end
                  end
                  CMD_PICK: begin
                     if (slot_valid_ff[cmd.cpu]) begin
                        res_task_valid = 1'b1;
                        res_chosen     = slot_task_ff[cmd.cpu];
                     end else if (count_ff != '0) begin
                        slot_valid_in[cmd.cpu] = 1'b1;
                        slot_task_in[cmd.cpu]  = head_ff;
                        res_task_valid         = 1'b1;
                        res_chosen             = head_ff;
                        rm_en                  = 1'b1;
                        rm_addr                = head_ff;
                     end else begin
                        res_status = ST_NOTHING;
                     end
                  end
                  CMD_YIELD: begin
                     if (!slot_valid_ff[cmd.cpu]) begin
                        res_status = ST_SLOT_EMPTY;
                     end else begin
                        slot_valid_in[cmd.cpu] = 1'b0;
                        app_en                 = 1'b1;
                        app_task               = slot_task_ff[cmd.cpu];
                     end
                  end
                  default: begin
                     res_status = cmd.reject_status;
                  end
               endcase

               if (app_en) begin
                  in_global_in[app_task] = 1'b1;
                  count_in               = count_ff + 1'b1;
                  if (count_ff == '0) begin
                     head_in = app_task;
                     tail_in = app_task;
                  end else begin
                     next_we = 1'b1;
                     next_wa = tail_ff;
                     next_wd = app_task;
                     prev_we = 1'b1;
                     prev_wa = app_task;
                     prev_wd = tail_ff;
                     tail_in = app_task;
                  end
               end

               if (rm_en) begin
                  in_global_in[rm_addr] = 1'b0;
                  if (count_ff <= COUNT_W'(1)) begin
                     count_in = '0;
                  end else begin
                     // Unlinking needs the neighbors, read from the link memories first.
                     rd_en              = 1'b1;
                     rd_addr            = rm_addr;
                     rm_task_in         = rm_addr;
                     pend_task_valid_in = res_task_valid;
                     pend_chosen_in     = res_chosen;
                     load               = 1'b0;
                     state_in           = BK_LINK;
                  end
               end
            end
         end
         BK_LINK: begin
            // The result register was emptied when this command was taken.
            count_in       = count_ff - 1'b1;
            load           = 1'b1;
            res_task_valid = pend_task_valid_ff;
            res_chosen     = pend_chosen_ff;
            state_in       = BK_IDLE;
            if (rm_task_ff == head_ff) begin
               head_in = next_rd_ff;
            end else if (rm_task_ff == tail_ff) begin
               tail_in = prev_rd_ff;
            end else begin
               next_we = 1'b1;
               next_wa = prev_rd_ff;
               next_wd = next_rd_ff;
               prev_we = 1'b1;
               prev_wa = next_rd_ff;
               prev_wd = prev_rd_ff;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_status_in     = rsp_status_ff;
      rsp_task_valid_in = rsp_task_valid_ff;
      rsp_chosen_in     = rsp_chosen_ff;
      if (load) begin
         rsp_valid_in      = 1'b1;
         rsp_status_in     = res_status;
         rsp_task_valid_in = res_task_valid;
         rsp_chosen_in     = res_chosen;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         slot_valid_ff <= '0;
         queued_ff     <= '0;
         in_global_ff  <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_valid_ff <= slot_valid_in;
         queued_ff     <= queued_in;
         in_global_ff  <= in_global_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_task_ff       <= slot_task_in;
      rm_task_ff         <= rm_task_in;
      pend_task_valid_ff <= pend_task_valid_in;
      pend_chosen_ff     <= pend_chosen_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_task_valid_ff  <= rsp_task_valid_in;
      rsp_chosen_ff      <= rsp_chosen_in;
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_link_mem[next_wa] <= next_wd;
      end
      if (prev_we) begin
         prev_link_mem[prev_wa] <= prev_wd;
      end
      if (rd_en) begin
         next_rd_ff <= next_link_mem[rd_addr];
         prev_rd_ff <= prev_link_mem[rd_addr];
      end
   end

endmodule

// ===== rtl/slot_and_global_fifo_scheduler_core.sv =====
// Top level of the slot and global FIFO task scheduler.
//
// Requests (req_op, req_cpu, req_task_id) enter on a valid/stall channel and
// each produces exactly one response (rsp_status, rsp_task_valid,
// rsp_chosen_task) on the rsp_ channel, in request order.
// A front end classifies requests into a two-entry command queue; the back
// end executes one command at a time against the slot table and the global
// FIFO, which is a doubly linked list held in two link memories.
// Order: the request is written into the command queue; the back end takes
// the queue head when idle with a free response register and registers the
// response, except when it unlinks a task from a FIFO holding more than one
// task: then the link memory read is registered first, and the relink write
// and the loading of the response register follow in the BK_LINK state.
// Throughput: one command per cycle while the response is not stalled; one
// that unlinks from such a FIFO blocks the next until its relink write.
// Reset empties all slots, the FIFO and the command queue; no clearing pass.
// A stalled response holds in its output register, the queue keeps taking
// requests until full, and req_stall is high while the queue is full.
`timescale 1ns / 1ps
module slot_and_global_fifo_scheduler_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_op,
   input  logic [2:0] req_cpu,
   input  logic [5:0] req_task_id,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_status,
   output logic       rsp_task_valid,
   output logic [5:0] rsp_chosen_task
);
   import sgfs_pkg::*;

   logic    q_push;
   cmd_type q_push_cmd;
   logic    q_full;
   logic    q_pop;
   logic    q_valid;
   cmd_type q_head_cmd;

   sgfs_front u_front (
      .req_valid   (req_valid),
      .req_op      (req_op),
      .req_cpu     (req_cpu),
      .req_task_id (req_task_id),
      .req_stall   (req_stall),
      .queue_full  (q_full),
      .push        (q_push),
      .push_cmd    (q_push_cmd)
   );

   sgfs_cmdq u_cmdq (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_push_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (q_head_cmd)
   );

   sgfs_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (q_valid),
      .cmd             (q_head_cmd),
      .cmd_pop         (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_task_valid  (rsp_task_valid),
      .rsp_chosen_task (rsp_chosen_task)
   );

   a_pop_needs_cmd: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("back end popped an empty command queue");

   a_pick_is_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_task_valid |-> rsp_status == ST_DONE)
      else $error("picked task reported with a failure status");

   a_no_task_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_task_valid |-> rsp_chosen_task == '0)
      else $error("chosen task not zero without a picked task");

   a_stall_blocks_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> !q_pop)
      else $error("command taken while the response register is held");

endmodule

// ===== verif/tb_slot_and_global_fifo_scheduler_core.sv =====
// Testbench of the slot and global FIFO scheduler core, checked against a task-state mirror.
`timescale 1ns / 1ps
module tb_slot_and_global_fifo_scheduler_core;
   import sgfs_pkg::*;

   typedef struct {
      status_type        status;
      logic              task_valid;
      logic [TASK_W-1:0] chosen;
   } reply_type;

   // Tracks every slot and the global FIFO and predicts each reply in order.
   class scheduler_mirror;
      bit                slot_valid[NUM_CPUS];
      logic [TASK_W-1:0] slot_task[NUM_CPUS];
      bit                queued[MAX_TASKS];
      bit                in_fifo[MAX_TASKS];
      logic [TASK_W-1:0] next_link[MAX_TASKS];
      logic [TASK_W-1:0] prev_link[MAX_TASKS];
      logic [TASK_W-1:0] head;
      logic [TASK_W-1:0] tail;
      int                fifo_count;
      reply_type         pending_replies[$];
      int                mismatch_count;

      function void push_tail(logic [TASK_W-1:0] t);
         if (fifo_count == 0) begin
            head = t;
            tail = t;
            prev_link[t] = t;
         end else begin
            next_link[tail] = t;
            prev_link[t] = tail;
            tail = t;
         end
         next_link[t] = t;
         in_fifo[t] = 1'b1;
         fifo_count++;
      endfunction

      function void unlink(logic [TASK_W-1:0] t);
         logic [TASK_W-1:0] p;
         logic [TASK_W-1:0] n;
         if (fifo_count <= 1) begin
            fifo_count = 0;
         end else begin
            if (t == head) begin
               head = next_link[t];
            end else if (t == tail) begin
               tail = prev_link[t];
            end else begin
               p = prev_link[t];
               n = next_link[t];
               next_link[p] = n;
               prev_link[n] = p;
            end
            fifo_count--;
         end
         in_fifo[t] = 1'b0;
      endfunction

      function void note_request(op_type op, logic [CPU_W-1:0] cpu, logic [TASK_W-1:0] tid);
         reply_type r;
         logic [TASK_W-1:0] t;
         r.status = ST_DONE;
         r.task_valid = 1'b0;
         r.chosen = '0;
         if (op == OP_DEQUEUE) begin
            if (!queued[tid]) begin
               r.status = ST_NOT_QUEUED;
            end else begin
               // A task outside the FIFO may sit in any CPU's slot.
               if (in_fifo[tid]) begin
                  unlink(tid);
               end else begin
                  for (int c = 0; c < NUM_CPUS; c++) begin
                     if (slot_valid[c] && slot_task[c] == tid) slot_valid[c] = 1'b0;
                  end
               end
               queued[tid] = 1'b0;
            end
         end else if (cpu >= NUM_CPUS) begin
            r.status = ST_SLOT_EMPTY;
         end else if (op == OP_ENQUEUE) begin
            if (queued[tid]) begin
               r.status = ST_ALREADY;
            end else begin
               if (!slot_valid[cpu]) begin
                  slot_valid[cpu] = 1'b1;
                  slot_task[cpu] = tid;
               end else begin
                  push_tail(tid);
               end
               queued[tid] = 1'b1;
            end
         end else if (op == OP_PICK) begin
            if (slot_valid[cpu]) begin
               r.task_valid = 1'b1;
               r.chosen = slot_task[cpu];
            end else if (fifo_count != 0) begin
               t = head;
               unlink(t);
               slot_valid[cpu] = 1'b1;
               slot_task[cpu] = t;
               r.task_valid = 1'b1;
               r.chosen = t;
            end else begin
               r.status = ST_NOTHING;
            end
         end else begin
            if (!slot_valid[cpu]) begin
               r.status = ST_SLOT_EMPTY;
            end else begin
               slot_valid[cpu] = 1'b0;
               push_tail(slot_task[cpu]);
            end
         end
         pending_replies.push_back(r);
      endfunction

      function void check_reply(logic [2:0] status, logic task_valid, logic [TASK_W-1:0] chosen);
         reply_type exp_reply;
         if (pending_replies.size() == 0) begin
            $error("unexpected response: status %0d task_valid %0d chosen_task %0d",
                   status, task_valid, chosen);
            mismatch_count++;
            return;
         end
         exp_reply = pending_replies.pop_front();
         if (status !== exp_reply.status) begin
            $error("status: expected %0d, actual %0d", exp_reply.status, status);
            mismatch_count++;
         end
         if (task_valid !== exp_reply.task_valid) begin
            $error("task_valid: expected %0d, actual %0d", exp_reply.task_valid, task_valid);
            mismatch_count++;
         end
         if (chosen !== exp_reply.chosen) begin
            $error("chosen_task: expected %0d, actual %0d", exp_reply.chosen, chosen);
            mismatch_count++;
         end
      endfunction

      function int pending_count();
         return pending_replies.size();
      endfunction

      // Returns a random task that is currently queued, or the fallback if none is.
      function logic [TASK_W-1:0] queued_task_or(logic [TASK_W-1:0] fallback);
         logic [TASK_W-1:0] ids[$];
         for (int i = 0; i < MAX_TASKS; i++) begin
            if (queued[i]) ids.push_back(TASK_W'(i));
         end
         if (ids.size() == 0) return fallback;
         return ids[$urandom_range(0, ids.size() - 1)];
      endfunction
   endclass

   localparam int IDLE_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 500;
   localparam int HOLD_CYCLES = 80;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_op = '0;
   logic [2:0] req_cpu = '0;
   logic [5:0] req_task_id = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_status;
   logic       rsp_task_valid;
   logic [5:0] rsp_chosen_task;

   scheduler_mirror sched = new();
   bit hold_wanted = 1'b0;
   int random_sent = 0;
   int idle_cycles = 0;

   slot_and_global_fifo_scheduler_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_cpu         (req_cpu),
      .req_task_id     (req_task_id),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_task_valid  (rsp_task_valid),
      .rsp_chosen_task (rsp_chosen_task)
   );

   always #1 clock = ~clock;

   task automatic send_request(op_type op, logic [CPU_W-1:0] cpu, logic [TASK_W-1:0] tid);
      req_valid <= 1'b1;
      req_op <= op;
      req_cpu <= cpu;
      req_task_id <= tid;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sched.note_request(op, cpu, tid);
   endtask

   task automatic send_random();
      int r;
      logic [CPU_W-1:0] cpu;
      logic [TASK_W-1:0] tid;
      r = $urandom_range(0, 99);
      cpu = CPU_W'($urandom_range(0, NUM_CPUS - 1));
      // Half the ids come from a narrow range so that tasks collide often.
      tid = $urandom_range(0, 1) ? TASK_W'($urandom_range(0, MAX_TASKS - 1))
                                 : TASK_W'($urandom_range(0, 11));
      if (r < 35) begin
         send_request(OP_ENQUEUE, cpu, tid);
      end else if (r < 60) begin
         if ($urandom_range(0, 9) < 7) tid = sched.queued_task_or(tid);
         send_request(OP_DEQUEUE, cpu, tid);
      end else if (r < 85) begin
         send_request(OP_PICK, cpu, tid);
      end else begin
         send_request(OP_YIELD, cpu, tid);
      end
      random_sent++;
   endtask

   task automatic idle_sender(int cycles);
      req_valid <= 1'b0;
      req_op <= 2'($urandom);
      req_cpu <= 3'($urandom);
      req_task_id <= 6'($urandom);
      repeat (cycles) @(posedge clock);
   endtask

   initial begin : stimulus
      int burst;
      bit hold_done;
      bit pause_done;
      hold_done = 1'b0;
      pause_done = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(OP_PICK,    3'd0, 6'd0);
      send_request(OP_YIELD,   3'd7, 6'd0);
      send_request(OP_DEQUEUE, 3'd0, 6'd63);
      send_request(OP_ENQUEUE, 3'd0, 6'd0);
      send_request(OP_ENQUEUE, 3'd0, 6'd63);
      send_request(OP_ENQUEUE, 3'd0, 6'd63);
      send_request(OP_ENQUEUE, 3'd5, 6'd0);
      send_request(OP_ENQUEUE, 3'd0, 6'd42);
      send_request(OP_ENQUEUE, 3'd0, 6'd21);
      send_request(OP_ENQUEUE, 3'd7, 6'd5);
      send_request(OP_PICK,    3'd0, 6'd0);
      send_request(OP_DEQUEUE, 3'd3, 6'd42);
      send_request(OP_PICK,    3'd3, 6'd0);
      send_request(OP_YIELD,   3'd3, 6'd0);
      send_request(OP_DEQUEUE, 3'd1, 6'd5);
      send_request(OP_DEQUEUE, 3'd1, 6'd63);
      send_request(OP_ENQUEUE, 3'd0, 6'd7);
      send_request(OP_DEQUEUE, 3'd0, 6'd21);
      send_request(OP_DEQUEUE, 3'd6, 6'd7);
      send_request(OP_PICK,    3'd4, 6'd0);
      send_request(OP_YIELD,   3'd0, 6'd0);
      send_request(OP_PICK,    3'd7, 6'd0);
      send_request(OP_DEQUEUE, 3'd2, 6'd0);
      send_request(OP_PICK,    3'd7, 6'd0);

      while (random_sent < RANDOM_ITEMS) begin
         if (!hold_done && random_sent >= 150) begin
            // The reply side holds off while requests keep coming, so the queue fills.
            hold_done = 1'b1;
            hold_wanted = 1'b1;
            repeat (12) send_random();
         end
         if (!pause_done && random_sent >= 320) begin
            pause_done = 1'b1;
            req_valid <= 1'b0;
            do @(posedge clock); while (sched.pending_count() != 0);
         end
         burst = $urandom_range(1, 20);
         repeat (burst) send_random();
         if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 8));
      end

      req_valid <= 1'b0;
      while (sched.pending_count() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sched.mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin : reply_side
      int mode;
      int tick;
      int hold_left;
      mode = 0;
      tick = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            sched.check_reply(rsp_status, rsp_task_valid, rsp_chosen_task);
         end
         tick++;
         if (hold_wanted && hold_left == 0) begin
            hold_wanted = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (tick % 50 == 0) mode = $urandom_range(0, 3);
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 1) == 1);
               2: rsp_stall <= (tick % 4 == 0);
               default: rsp_stall <= ($urandom_range(0, 9) < 8);
            endcase
         end
      end
   end

   // Ends the run if neither channel moves a transfer for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// ===== sim.f =====
rtl/sgfs_pkg.sv
rtl/sgfs_front.sv
rtl/sgfs_cmdq.sv
rtl/sgfs_back.sv
rtl/slot_and_global_fifo_scheduler_core.sv
verif/tb_slot_and_global_fifo_scheduler_core.sv
